@@ hdl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;

  // Bitmap word: one used mark per bit.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  localparam int unsigned CFG_W = 13;
  localparam int unsigned BLK_W = 12;
  localparam int unsigned IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_DATA_START   = 1'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_BLOCKS = 1'd1;

  localparam logic [CFG_W-1:0] DATA_START_RST   = 13'd0;
  localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_MODIFY,
    S_SCAN,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] data_start;
    logic [CFG_W-1:0] total_blocks;
  } cfg_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted;
    status_e          status;
  } res_t;

endpackage

@@ hdl/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ hdl/ffba_pick.sv @@
// ----------------------------------------------------------------------------
// ffba_pick
// Priority encoder: position of the lowest set bit of one bitmap word.
// ----------------------------------------------------------------------------
module ffba_pick
  import ffba_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  output logic              found_o,
  output logic [BIT_W-1:0]  idx_o
);

  always_comb begin
    idx_o = '0;
    // Walk from the top so that the lowest set bit wins.
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        idx_o = BIT_W'(i);
      end
    end
  end

  assign found_o = |word_i;

endmodule

@@ hdl/ffba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffba_ctrl
// Command sequencer: read-modify-write of bitmap words, first-fit scan,
// initialise and post-reset clearing sweeps.
// ----------------------------------------------------------------------------
module ffba_ctrl
  import ffba_pkg::*;
#(
  parameter int unsigned MaxBlocks = MAX_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [1:0]       cmd_i,
  input  logic [BLK_W-1:0] block_i,
  output logic             ready_o,
  input  logic             slot_free_i,
  output logic             push_o,
  output res_t             res_o
);

  localparam int unsigned NumWords = (MaxBlocks + WORD_W - 1) / WORD_W;
  localparam int unsigned AddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned SizeW    = $clog2(MaxBlocks + 1);
  localparam int unsigned CmpW     = (SizeW > CFG_W) ? SizeW : CFG_W;
  localparam int unsigned PosW     = (CmpW > AddrW + BIT_W + 1) ? CmpW : AddrW + BIT_W + 1;
  localparam logic [AddrW-1:0] LastWord = AddrW'(NumWords - 1);

  state_e state_q, state_d;
  cmd_e   cmd;
  logic   accept;

  logic [PosW-1:0]    ds_p, tb_p, size_p, lim_p, last_p, blk_p;
  logic               range_ok, alloc_ok;
  logic [AddrW-1:0]   ds_word, last_word, blk_word;
  logic [AddrW:0]     lim_word;

  logic [AddrW-1:0]   word_q, word_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic               mark_q, mark_d;
  logic [AddrW:0]     scan_q, scan_d;
  logic               chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]   chk_word_q, chk_word_d;
  logic [AddrW-1:0]   sweep_q, sweep_d;
  res_t               res_q, res_d;

  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, rd_data;

  logic [WORD_W-1:0]  mask_lo, mask_hi, free_bits, init_pat;
  logic               hit;
  logic [BIT_W-1:0]   hit_idx;
  logic [AddrW+BIT_W-1:0] hit_pos;

  assign cmd    = cmd_e'(cmd_i);
  assign accept = in_valid_i && (state_q == S_IDLE);

  // Effective partition size and derived word positions.
  assign ds_p     = PosW'(cfg_i.data_start);
  assign tb_p     = PosW'(cfg_i.total_blocks);
  assign size_p   = (tb_p > PosW'(MaxBlocks)) ? PosW'(MaxBlocks) : tb_p;
  assign lim_p    = (ds_p < size_p) ? ds_p : size_p;
  assign last_p   = size_p - PosW'(1);
  assign blk_p    = PosW'(block_i);
  assign range_ok = blk_p < size_p;
  assign alloc_ok = ds_p < size_p;
  assign ds_word   = ds_p[AddrW+BIT_W-1:BIT_W];
  assign last_word = last_p[AddrW+BIT_W-1:BIT_W];
  assign blk_word  = blk_p[AddrW+BIT_W-1:BIT_W];
  assign lim_word  = lim_p[AddrW+BIT_W:BIT_W];

  // Search window inside the word under test.
  assign mask_lo   = (chk_word_q == ds_word) ? ({WORD_W{1'b1}} << ds_p[BIT_W-1:0])
                                             : {WORD_W{1'b1}};
  assign mask_hi   = (chk_word_q == last_word) ? ({WORD_W{1'b1}} >> (~last_p[BIT_W-1:0]))
                                               : {WORD_W{1'b1}};
  assign free_bits = ~rd_data & mask_lo & mask_hi;
  assign hit_pos   = {chk_word_q, hit_idx};

  // Initialise pattern: marks set below min(data_start, size).
  always_comb begin
    if ({1'b0, sweep_q} < lim_word) begin
      init_pat = {WORD_W{1'b1}};
    end else if ({1'b0, sweep_q} == lim_word) begin
      init_pat = ~({WORD_W{1'b1}} << lim_p[BIT_W-1:0]);
    end else begin
      init_pat = '0;
    end
  end

  ffba_pick u_pick (
    .word_i  (free_bits),
    .found_o (hit),
    .idx_o   (hit_idx)
  );

  ffba_ram #(
    .Width (WORD_W),
    .Depth (NumWords)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (rd_data)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sweep_q == LastWord) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            CMD_INIT:  state_d = S_INIT;
            CMD_MARK,
            CMD_FREE:  state_d = range_ok ? S_MODIFY : S_PUSH;
            CMD_ALLOC: state_d = alloc_ok ? S_SCAN : S_PUSH;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        if (sweep_q == LastWord) state_d = S_PUSH;
      end
      S_MODIFY: state_d = S_PUSH;
      S_SCAN: begin
        if (chk_vld_q && (hit || (chk_word_q == last_word))) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    ready_o    = 1'b0;
    push_o     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = word_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = blk_word;
    word_d     = word_q;
    bit_d      = bit_q;
    mark_d     = mark_q;
    scan_d     = scan_q;
    chk_vld_d  = chk_vld_q;
    chk_word_d = chk_word_q;
    sweep_d    = sweep_q;
    res_d      = res_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + AddrW'(1);
      end
      S_IDLE: begin
        ready_o = 1'b1;
        if (accept) begin
          res_d.granted = '0;
          res_d.status  = ST_OK;
          sweep_d       = '0;
          case (cmd)
            CMD_MARK,
            CMD_FREE: begin
              if (!range_ok) begin
                res_d.status = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = blk_word;
                word_d    = blk_word;
                bit_d     = blk_p[BIT_W-1:0];
                mark_d    = (cmd == CMD_MARK);
              end
            end
            CMD_ALLOC: begin
              if (!alloc_ok) begin
                res_d.status = ST_NOSPACE;
              end else begin
                scan_d    = {1'b0, ds_word};
                chk_vld_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = init_pat;
        sweep_d   = sweep_q + AddrW'(1);
      end
      S_MODIFY: begin
        ram_we    = 1'b1;
        ram_waddr = word_q;
        ram_wdata = mark_q ? (rd_data | (WORD_W'(1) << bit_q))
                           : (rd_data & ~(WORD_W'(1) << bit_q));
      end
      S_SCAN: begin
        // Reads run one word ahead of the check of the returned word.
        chk_vld_d = 1'b0;
        if (scan_q <= {1'b0, last_word}) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_q[AddrW-1:0];
          scan_d     = scan_q + (AddrW+1)'(1);
          chk_vld_d  = 1'b1;
          chk_word_d = scan_q[AddrW-1:0];
        end
        if (chk_vld_q) begin
          if (hit) begin
            ram_we        = 1'b1;
            ram_waddr     = chk_word_q;
            ram_wdata     = rd_data | (WORD_W'(1) << hit_idx);
            res_d.granted = BLK_W'(hit_pos);
            res_d.status  = ST_OK;
          end else if (chk_word_q == last_word) begin
            res_d.status = ST_NOSPACE;
          end
        end
      end
      S_PUSH: begin
        push_o = slot_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      sweep_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    bit_q      <= bit_d;
    mark_q     <= mark_d;
    scan_q     <= scan_d;
    chk_word_q <= chk_word_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_no_same_word_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("bitmap word read and written in the same cycle");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing sweep entered outside reset");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (res_q.status != ST_OK)) |-> (res_q.granted == '0))
    else $error("failed request carries a granted block");

  a_range_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((cmd == CMD_MARK) || (cmd == CMD_FREE)) && !range_ok)
      |=> (state_q == S_PUSH))
    else $error("out-of-range request touched the bitmap");
`endif

endmodule

@@ hdl/first_fit_block_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_bitmap_allocator
// Block allocator with a one-bit used mark per block kept in a word-wide RAM.
// ----------------------------------------------------------------------------
// One command is worked at a time. Mark used and free take a read and a
// write-back of one 32-bit bitmap word before the result is pushed into the
// output register; a block out of range goes straight to the push. Allocate
// reads the words from the one holding data_start upward, one word a cycle
// with a registered RAM read, and answers once a word shows a free block in
// the search window or the word holding the last block has been checked.
// Initialise writes every bitmap word once. After reset the block clears
// every bitmap word (128 by default) before it takes the first transfer;
// configuration writes are taken at any time. A finished result waits in an
// output register.
module first_fit_block_bitmap_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [BLK_W-1:0] block_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [BLK_W-1:0] granted_block_o,
  output logic [1:0]       status_o
);

  cfg_t cfg_q;
  logic ready, push, slot_free;
  res_t res;
  logic out_valid_q;
  res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_start   <= DATA_START_RST;
      cfg_q.total_blocks <= TOTAL_BLOCKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DATA_START:   cfg_q.data_start   <= cfg_data_i;
        REG_TOTAL_BLOCKS: cfg_q.total_blocks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  ffba_ctrl #(
    .MaxBlocks (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .block_i     (block_i),
    .ready_o     (ready),
    .slot_free_i (slot_free),
    .push_o      (push),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign in_stall_o      = !ready;
  assign out_valid_o     = out_valid_q;
  assign granted_block_o = out_q.granted;
  assign status_o        = out_q.status;

endmodule

@@ tb/sv/alloc_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_check_pkg
// Bitmap predictor and result scoreboard for the first-fit block allocator.
// ----------------------------------------------------------------------------
package alloc_check_pkg;
  import ffba_pkg::*;

  class alloc_scoreboard;
    logic [MAX_BLOCKS_DEF-1:0] used_map;
    logic [CFG_W-1:0]          data_start;
    logic [CFG_W-1:0]          total_blocks;
    res_t                      expected_q[$];
    int unsigned               mismatches;
    int unsigned               commands;
    int unsigned               grants;
    int unsigned               no_space;
    int unsigned               out_of_range;

    function new();
      used_map     = '0;
      data_start   = DATA_START_RST;
      total_blocks = TOTAL_BLOCKS_RST;
      mismatches   = 0;
      commands     = 0;
      grants       = 0;
      no_space     = 0;
      out_of_range = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_DATA_START) begin
        data_start = val;
      end else if (idx == REG_TOTAL_BLOCKS) begin
        total_blocks = val;
      end
    endfunction

    // The partition never extends past the bitmap itself.
    function int unsigned part_size();
      int unsigned n;
      n = total_blocks;
      if (n > MAX_BLOCKS_DEF) n = MAX_BLOCKS_DEF;
      return n;
    endfunction

    // Applies one accepted command to the bitmap copy and queues its result.
    function void note_command(cmd_e cmd, logic [BLK_W-1:0] blk);
      int unsigned size;
      int unsigned i;
      res_t        r;
      size      = part_size();
      r.granted = '0;
      r.status  = ST_OK;
      case (cmd)
        CMD_INIT: begin
          for (i = 0; i < MAX_BLOCKS_DEF; i++) begin
            used_map[i] = (i < data_start) && (i < size);
          end
        end
        CMD_MARK, CMD_FREE: begin
          if (blk >= size) begin
            r.status = ST_RANGE;
          end else begin
            used_map[blk] = (cmd == CMD_MARK);
          end
        end
        default: begin
          r.status = ST_NOSPACE;
          for (i = data_start; i < size; i++) begin
            if (!used_map[i]) begin
              used_map[i] = 1'b1;
              r.granted   = BLK_W'(i);
              r.status    = ST_OK;
              break;
            end
          end
        end
      endcase
      commands++;
      if (cmd == CMD_ALLOC && r.status == ST_OK) grants++;
      if (r.status == ST_NOSPACE) no_space++;
      if (r.status == ST_RANGE) out_of_range++;
      expected_q.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void check_result(logic [BLK_W-1:0] granted, logic [1:0] status);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing pending: granted=%0d status=%0d",
                       granted, status));
        return;
      end
      exp_r = expected_q.pop_front();
      if (granted !== exp_r.granted || status !== exp_r.status) begin
        flag($sformatf("expected granted=%0d status=%0d, got granted=%0d status=%0d",
                       exp_r.granted, exp_r.status, granted, status));
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
// A short directed sequence exercises allocation from block zero, marks at
// the top end of the map, reserved and out-of-range blocks, an empty search
// range and a zero-sized partition. Randomized phases then run under changing
// register settings with random stalls on both channels, save in the last two.
// Every result is checked against a bitmap predictor kept in the scoreboard.
module tb;
  import ffba_pkg::*;
  import alloc_check_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned PHASE_ITEMS    = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       cmd_i;
  logic [BLK_W-1:0] block_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [BLK_W-1:0] granted_block_o;
  logic [1:0]       status_o;

  alloc_scoreboard sb = new();

  bit          quiet;
  bit          stalling;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned settings;

  first_fit_block_bitmap_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .block_i        (block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_block_o(granted_block_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver back-pressure alternates between stall bursts and free runs.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stalling   = ($urandom_range(0, 2) == 0);
      stall_left = stalling ? $urandom_range(1, 15) : $urandom_range(1, 40);
    end
    stall_left--;
    out_stall_i <= stalling && !quiet;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(granted_block_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", sb.expected_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(cmd_e cmd, logic [BLK_W-1:0] blk);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    block_i    = blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(cmd, blk);
  endtask

  // Holds the sender off until every pending result has been taken.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] start, logic [CFG_W-1:0] total);
    wait_drained();
    write_reg(REG_DATA_START, start);
    write_reg(REG_TOTAL_BLOCKS, total);
    settings++;
  endtask

  // Block numbers lean toward the live partition so that marks and frees
  // mostly hit real blocks, with a share spread over the whole field.
  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned hi;
    hi = sb.part_size();
    if (hi == 0 || $urandom_range(0, 9) < 3) return BLK_W'($urandom_range(0, 4095));
    hi = hi + 2;
    if (hi > 4095) hi = 4095;
    return BLK_W'($urandom_range(0, hi));
  endfunction

  task automatic random_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      send(CMD_INIT, BLK_W'($urandom_range(0, 4095)));
    end else if (roll < 45) begin
      send(CMD_ALLOC, BLK_W'($urandom_range(0, 4095)));
    end else if (roll < 72) begin
      send(CMD_MARK, pick_block());
    end else begin
      send(CMD_FREE, pick_block());
    end
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      n;
    int unsigned      span;
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] total;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_DATA_START;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_INIT;
    block_i     = '0;
    out_stall_i = 1'b0;
    quiet       = 1'b0;
    stalling    = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    settings    = 1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: allocation from block zero and marks at the top end.
    send(CMD_ALLOC, 12'd0);
    send(CMD_ALLOC, 12'hFFF);
    send(CMD_MARK, 12'd4095);
    send(CMD_MARK, 12'd2);
    send(CMD_ALLOC, 12'd0);
    send(CMD_FREE, 12'd0);
    send(CMD_ALLOC, 12'd0);

    // Small partition: reserved blocks, freeing one of them, out-of-range
    // blocks, and allocating until the partition is full. Initialise also
    // clears the mark left on the top block.
    configure(13'd3, 13'd10);
    send(CMD_INIT, 12'd0);
    send(CMD_FREE, 12'd1);
    send(CMD_ALLOC, 12'd0);
    send(CMD_MARK, 12'd10);
    send(CMD_FREE, 12'd4095);
    send(CMD_MARK, 12'd9);
    repeat (6) send(CMD_ALLOC, 12'd0);

    // Search range empty because the data start sits at the partition size.
    configure(13'd4096, 13'd4096);
    send(CMD_ALLOC, 12'd0);
    send(CMD_INIT, 12'd0);

    // Zero-sized partition.
    configure(13'd0, 13'd0);
    send(CMD_MARK, 12'd0);
    send(CMD_ALLOC, 12'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          start = 13'd100;
          total = 13'd8191;
        end
        1: begin
          start = 13'd4000;
          total = 13'd4096;
        end
        2: begin
          start = 13'd8191;
          total = 13'd8191;
        end
        3: begin
          start = 13'd0;
          total = 13'd4096;
        end
        default: begin
          start = CFG_W'($urandom_range(0, 4096));
          if ($urandom_range(0, 3) == 0) begin
            total = CFG_W'($urandom_range(0, 8191));
          end else begin
            span  = start + $urandom_range(0, 200);
            total = CFG_W'((span > 8191) ? 8191 : span);
          end
        end
      endcase
      quiet = (phase >= PHASES - 2);
      configure(start, total);
      if ($urandom_range(0, 1) == 1) send(CMD_INIT, BLK_W'($urandom_range(0, 4095)));
      for (n = 0; n < PHASE_ITEMS; n++) random_command();
    end

    wait_drained();
    repeat (150) @(posedge clk_i);

    $display("Ran %0d commands under %0d register settings.", sb.commands, settings);
    $display("Grants %0d, no free block %0d, out of range %0d, mismatches %0d.",
             sb.grants, sb.no_space, sb.out_of_range, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_pick.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_bitmap_allocator.sv
tb/sv/alloc_check_pkg.sv
tb/sv/tb.sv
